FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file qdec_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define QD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("quadrature decoder check failed");

// Checked at every edge, reset included.
`define QD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("quadrature decoder check failed");

`endif

FILE: hdl/qdec_pkg.sv
// Types and constants of the quadrature decoder with speed estimate.
`timescale 1ns / 1ps

package qdec_pkg;

  // Width of the internal position counter.
  localparam int PosBits = 32;

  // Speed numerator: 256e6 = 1e6 us/s with 8 fraction bits.
  localparam int QuotBits = 28;
  localparam logic [QuotBits-1:0] SpeedNum = 28'd256000000;

  localparam logic [31:0] TimeoutReset = 32'd2000000;

  // step_dir codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef struct packed {
    logic        chan_a;
    logic        chan_b;
    logic [31:0] now_us;
  } in_t;

  typedef struct packed {
    logic signed [31:0]   position;
    logic [1:0]           step_dir;
    logic [31:0]          edge_period_us;
    logic [QuotBits-1:0]  speed_q8;
  } out_t;

endpackage

FILE: hdl/qdec_div.sv
// Bit-serial restoring divider: SpeedNum / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module qdec_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [31:0]                   divisor,
  output logic                          busy,
  output logic [qdec_pkg::QuotBits-1:0] quot
);

  localparam int CntW = $clog2(qdec_pkg::QuotBits);

  logic                          busy_r, busy_nxt;
  logic [CntW-1:0]               cnt_r, cnt_nxt;
  logic [31:0]                   dvs_r;
  logic [31:0]                   rem_r;
  logic [qdec_pkg::QuotBits-1:0] num_r;
  logic [qdec_pkg::QuotBits-1:0] quot_r;
  logic [32:0]                   trial;
  logic                          fits;

  // next partial remainder: shift in the next numerator bit
  assign trial = {rem_r, num_r[qdec_pkg::QuotBits-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(qdec_pkg::QuotBits - 1);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r  <= divisor;
      rem_r  <= '0;
      num_r  <= qdec_pkg::SpeedNum;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
      num_r  <= {num_r[qdec_pkg::QuotBits-2:0], 1'b0};
      quot_r <= {quot_r[qdec_pkg::QuotBits-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

FILE: hdl/quadrature_decoder_with_speed.sv
// Top level: x4 quadrature decoder with edge-period speed estimate.
`timescale 1ns / 1ps
//
// Input channel (in_valid / in_stall / in_word): one word per sample with
// channel levels A and B and a free-running microsecond timestamp.
// Output channel (out_valid / out_stall / out_word): one word per sample
// with position, step direction, last step period and speed (Q8 steps/s).
// Config channel (cfg_valid / cfg_ready / cfg_data): the period timeout,
// always ready; write it only while no sample is in flight.
// A sample without a counted edge goes through ST_HOLD into the output
// register; the next sample is taken once the state is back in ST_IDLE.
// A counted edge starts the bit-serial divider, one quotient bit per cycle;
// the sample waits in ST_DIV until the divider is done, then goes through
// ST_HOLD into the output register. One sample is in work at a time.
// The output register lets a new sample be accepted while the previous
// word waits. If out_stall is held, the next finished word waits inside
// and in_stall stays high until the output register frees.
// Synchronous reset clears position, previous levels, edge time, period,
// and sets the timeout to 2000000 us.

module quadrature_decoder_with_speed (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  qdec_pkg::in_t    in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output qdec_pkg::out_t   out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic                                 prev_a_r, prev_b_r;
  logic signed [qdec_pkg::PosBits-1:0]  cnt_r, cnt_nxt;
  logic [1:0]                           dir_r, dir_nxt;
  logic [31:0]                          last_time_r, last_time_nxt;
  logic [31:0]                          period_r, period_nxt;
  logic [31:0]                          tmo_r;
  logic                                 out_valid_r, out_valid_nxt;
  qdec_pkg::out_t                       out_r, out_nxt;

  logic                                 in_acc;
  logic                                 a, b;
  logic                                 up, down;
  logic [31:0]                          new_period;
  logic                                 div_busy;
  logic [qdec_pkg::QuotBits-1:0]        div_quot;
  logic                                 out_free;

  assign a = in_word.chan_a;
  assign b = in_word.chan_b;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // up conditions take priority over down when both channels toggle
  assign up   = (a && !prev_a_r && !b) || (!a && prev_a_r && b) ||
                (b && !prev_b_r && a)  || (!b && prev_b_r && !a);
  assign down = (b && !prev_b_r && !a) || (!b && prev_b_r && a) ||
                (a && !prev_a_r && b)  || (!a && prev_a_r && !b);

  assign new_period = in_word.now_us - last_time_r;

  qdec_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc && (up || down)),
    .divisor (new_period),
    .busy    (div_busy),
    .quot    (div_quot)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dir_nxt       = dir_r;
    last_time_nxt = last_time_r;
    period_nxt    = period_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dir_nxt   = qdec_pkg::DIR_NONE;
          state_nxt = ST_HOLD;
          if (up) begin
            cnt_nxt = cnt_r + 1'b1;
            dir_nxt = qdec_pkg::DIR_UP;
          end else if (down) begin
            cnt_nxt = cnt_r - 1'b1;
            dir_nxt = qdec_pkg::DIR_DOWN;
          end
          if (up || down) begin
            period_nxt    = new_period;
            last_time_nxt = in_word.now_us;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_nxt.position       = 32'(cnt_r);
          out_nxt.step_dir       = dir_r;
          out_nxt.edge_period_us = period_r;
          // quotient is from the last counted edge; gated by current period
          out_nxt.speed_q8       = (period_r != '0 && period_r < tmo_r) ? div_quot : '0;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_a_r    <= 1'b0;
      prev_b_r    <= 1'b0;
      cnt_r       <= '0;
      dir_r       <= qdec_pkg::DIR_NONE;
      last_time_r <= '0;
      period_r    <= '0;
      tmo_r       <= qdec_pkg::TimeoutReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dir_r       <= dir_nxt;
      last_time_r <= last_time_nxt;
      period_r    <= period_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        prev_a_r <= a;
        prev_b_r <= b;
      end
      if (cfg_valid && cfg_ready) begin
        tmo_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

FILE: hdl/qdec_chk.sv
// Port-level checker for the quadrature decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qdec_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input qdec_pkg::out_t  out_word
);

  logic speed_nz;
  logic period_ok;

  // a nonzero speed needs a period that the numerator can still divide
  assign speed_nz  = out_valid && (out_word.speed_q8 != '0);
  assign period_ok = (out_word.edge_period_us != '0) &&
                     (out_word.edge_period_us <= 32'd256000000);

  `QD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_word))
  `QD_ASSERT(a_dir_code, clk, rst_n, out_valid |-> out_word.step_dir != 2'd3)
  `QD_ASSERT(a_speed_period, clk, rst_n, speed_nz |-> period_ok)
  `QD_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind quadrature_decoder_with_speed qdec_chk u_qdec_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
